### rtl/core/rtdca_pkg.sv
// Package for the RTD code to temperature block: widths, division constants,
// the PT100 lookup ROM and the item types passed between the pipeline modules.
// No dependencies.
package rtdca_pkg;

  localparam int CODE_W       = 15;
  localparam int TEMP_W       = 18;
  localparam int SUM_W        = 24;
  localparam int ROM_DEPTH    = 329;
  localparam int ROM_W        = 16;
  localparam int IDX_W        = 9;
  localparam int FRAC_W       = 7;
  localparam int INTERP_W     = 23;
  localparam int INTERP_MAG_W = 22;
  localparam int MAG_W        = 24;

  // code / 100 as (code * 5243) >> 19, exact for every 15-bit code
  localparam int DIV100_MUL_W  = 13;
  localparam logic [DIV100_MUL_W-1:0] DIV100_MUL = 13'd5243;
  localparam int DIV100_SHIFT  = 19;

  // magnitude / 25 as (mag * 5368710) >> 27, exact below 2^22
  localparam int DIV25_MUL_W   = 23;
  localparam logic [DIV25_MUL_W-1:0] DIV25_MUL = 23'd5368710;
  localparam int DIV25_SHIFT   = 27;

  // shift for the averaging reciprocal, exact for magnitudes below 2^24
  localparam int AVG_RECIP_W     = 32;
  localparam int AVG_RECIP_SHIFT = 31;

  // PT100 table in units of 1/25 degree, one entry per 100 codes
  localparam logic signed [ROM_W-1:0] RTD_ROM [ROM_DEPTH] = '{
    -16'sd6172, -16'sd6101, -16'sd6030, -16'sd5958, -16'sd5887,
    -16'sd5816, -16'sd5745, -16'sd5673, -16'sd5602, -16'sd5531,
    -16'sd5459, -16'sd5388, -16'sd5316, -16'sd5244, -16'sd5173,
    -16'sd5101, -16'sd5029, -16'sd4957, -16'sd4885, -16'sd4813,
    -16'sd4741, -16'sd4669, -16'sd4597, -16'sd4525, -16'sd4452,
    -16'sd4380, -16'sd4308, -16'sd4235, -16'sd4163, -16'sd4090,
    -16'sd4017, -16'sd3945, -16'sd3872, -16'sd3799, -16'sd3726,
    -16'sd3653, -16'sd3580, -16'sd3507, -16'sd3434, -16'sd3361,
    -16'sd3287, -16'sd3214, -16'sd3141, -16'sd3067, -16'sd2994,
    -16'sd2920, -16'sd2847, -16'sd2773, -16'sd2699, -16'sd2625,
    -16'sd2552, -16'sd2478, -16'sd2404, -16'sd2330, -16'sd2255,
    -16'sd2181, -16'sd2107, -16'sd2033, -16'sd1958, -16'sd1884,
    -16'sd1809, -16'sd1735, -16'sd1660, -16'sd1585, -16'sd1511,
    -16'sd1436, -16'sd1361, -16'sd1286, -16'sd1211, -16'sd1136,
    -16'sd1061, -16'sd986,  -16'sd910,  -16'sd835,  -16'sd759,
    -16'sd684,  -16'sd608,  -16'sd533,  -16'sd457,  -16'sd381,
    -16'sd306,  -16'sd230,  -16'sd154,  -16'sd78,   -16'sd2,
    16'sd75,    16'sd151,   16'sd227,   16'sd304,   16'sd380,
    16'sd456,   16'sd533,   16'sd610,   16'sd686,   16'sd763,
    16'sd840,   16'sd917,   16'sd994,   16'sd1071,  16'sd1148,
    16'sd1225,  16'sd1303,  16'sd1380,  16'sd1458,  16'sd1535,
    16'sd1613,  16'sd1690,  16'sd1768,  16'sd1846,  16'sd1924,
    16'sd2002,  16'sd2080,  16'sd2158,  16'sd2236,  16'sd2314,
    16'sd2392,  16'sd2471,  16'sd2549,  16'sd2628,  16'sd2706,
    16'sd2785,  16'sd2864,  16'sd2943,  16'sd3022,  16'sd3101,
    16'sd3180,  16'sd3259,  16'sd3338,  16'sd3417,  16'sd3497,
    16'sd3576,  16'sd3656,  16'sd3735,  16'sd3815,  16'sd3895,
    16'sd3975,  16'sd4054,  16'sd4134,  16'sd4215,  16'sd4295,
    16'sd4375,  16'sd4455,  16'sd4536,  16'sd4616,  16'sd4697,
    16'sd4777,  16'sd4858,  16'sd4939,  16'sd5020,  16'sd5101,
    16'sd5182,  16'sd5263,  16'sd5344,  16'sd5426,  16'sd5507,
    16'sd5588,  16'sd5670,  16'sd5752,  16'sd5833,  16'sd5915,
    16'sd5997,  16'sd6079,  16'sd6161,  16'sd6243,  16'sd6325,
    16'sd6408,  16'sd6490,  16'sd6573,  16'sd6655,  16'sd6738,
    16'sd6821,  16'sd6904,  16'sd6987,  16'sd7070,  16'sd7153,
    16'sd7236,  16'sd7319,  16'sd7403,  16'sd7486,  16'sd7570,
    16'sd7653,  16'sd7737,  16'sd7821,  16'sd7905,  16'sd7989,
    16'sd8073,  16'sd8157,  16'sd8241,  16'sd8326,  16'sd8410,
    16'sd8495,  16'sd8580,  16'sd8664,  16'sd8749,  16'sd8834,
    16'sd8919,  16'sd9004,  16'sd9090,  16'sd9175,  16'sd9260,
    16'sd9346,  16'sd9432,  16'sd9517,  16'sd9603,  16'sd9689,
    16'sd9775,  16'sd9861,  16'sd9948,  16'sd10034, 16'sd10120,
    16'sd10207, 16'sd10293, 16'sd10380, 16'sd10467, 16'sd10554,
    16'sd10641, 16'sd10728, 16'sd10815, 16'sd10903, 16'sd10990,
    16'sd11078, 16'sd11165, 16'sd11253, 16'sd11341, 16'sd11429,
    16'sd11517, 16'sd11605, 16'sd11693, 16'sd11782, 16'sd11870,
    16'sd11959, 16'sd12048, 16'sd12137, 16'sd12225, 16'sd12315,
    16'sd12404, 16'sd12493, 16'sd12582, 16'sd12672, 16'sd12761,
    16'sd12851, 16'sd12941, 16'sd13031, 16'sd13121, 16'sd13211,
    16'sd13301, 16'sd13392, 16'sd13482, 16'sd13573, 16'sd13664,
    16'sd13755, 16'sd13845, 16'sd13937, 16'sd14028, 16'sd14119,
    16'sd14211, 16'sd14302, 16'sd14394, 16'sd14486, 16'sd14578,
    16'sd14670, 16'sd14762, 16'sd14854, 16'sd14946, 16'sd15039,
    16'sd15132, 16'sd15224, 16'sd15317, 16'sd15410, 16'sd15503,
    16'sd15597, 16'sd15690, 16'sd15784, 16'sd15877, 16'sd15971,
    16'sd16065, 16'sd16159, 16'sd16253, 16'sd16348, 16'sd16442,
    16'sd16537, 16'sd16631, 16'sd16726, 16'sd16821, 16'sd16916,
    16'sd17011, 16'sd17107, 16'sd17202, 16'sd17298, 16'sd17394,
    16'sd17490, 16'sd17586, 16'sd17682, 16'sd17778, 16'sd17875,
    16'sd17971, 16'sd18068, 16'sd18165, 16'sd18262, 16'sd18359,
    16'sd18456, 16'sd18554, 16'sd18651, 16'sd18749, 16'sd18847,
    16'sd18945, 16'sd19043, 16'sd19141, 16'sd19240, 16'sd19339,
    16'sd19437, 16'sd19536, 16'sd19635, 16'sd19734, 16'sd19834,
    16'sd19933, 16'sd20033, 16'sd20133, 16'sd20233, 16'sd20333,
    16'sd20433, 16'sd20534, 16'sd20634, 16'sd20735, 16'sd20836,
    16'sd20937, 16'sd21038, 16'sd21140, 16'sd21241
  };

  typedef struct packed {
    logic              fresh;
    logic [CODE_W-1:0] code;
  } reading_t;

  typedef struct packed {
    logic                     fresh;
    logic signed [TEMP_W-1:0] temp;
  } sample_t;

endpackage

### rtl/core/rtdca_interp.sv
// Four-stage pipeline from RTD code to temperature in hundredths of a degree:
// split by 100, ROM interpolation, magnitude, divide by 25.
// Depends on rtdca_pkg.
module rtdca_interp
  import rtdca_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  reading_t in_item,
  output logic     out_valid,
  input  logic     out_ready,
  output sample_t  out_item
);

  logic en_a, en_b, en_c, en_d;
  logic va, vb, vc, vd;

  // stage a: index and fraction
  logic [CODE_W+DIV100_MUL_W-1:0] div_prod;
  logic [IDX_W-1:0]               idx_in;
  logic [CODE_W-1:0]              idx_x100;
  logic [CODE_W-1:0]              frac_full;
  logic                           fresh_a;
  logic [IDX_W-1:0]               idx_a;
  logic [FRAC_W-1:0]              frac_a;

  // stage b: interpolated sum
  logic signed [ROM_W-1:0]    lo, hi, step;
  logic signed [7:0]          step_n;
  logic signed [15:0]         slope;
  logic signed [INTERP_W-1:0] lo_ext, lo_x100, interp_next;
  logic                       fresh_b;
  logic signed [INTERP_W-1:0] interp_b;

  // stage c: sign and magnitude
  logic [INTERP_W-1:0]     interp_abs;
  logic                    fresh_c;
  logic                    neg_c;
  logic [INTERP_MAG_W-1:0] mag_c;

  // stage d: divide by 25
  logic [INTERP_MAG_W+DIV25_MUL_W-1:0] q_prod;
  logic [TEMP_W-1:0]                   q;
  logic [TEMP_W-1:0]                   temp_d;

  assign en_d     = !vd || out_ready;
  assign en_c     = !vc || en_d;
  assign en_b     = !vb || en_c;
  assign en_a     = !va || en_b;
  assign in_ready = en_a;

  assign div_prod  = in_item.code * DIV100_MUL;
  assign idx_in    = div_prod[DIV100_SHIFT +: IDX_W];
  assign idx_x100  = ({6'b0, idx_in} << 6) + ({6'b0, idx_in} << 5) + ({6'b0, idx_in} << 2);
  assign frac_full = in_item.code - idx_x100;

  assign lo          = RTD_ROM[idx_a];
  assign hi          = RTD_ROM[idx_a + 9'd1];
  assign step        = hi - lo;
  assign step_n      = step[7:0];
  assign slope       = step_n * $signed({1'b0, frac_a});
  assign lo_ext      = {{(INTERP_W-ROM_W){lo[ROM_W-1]}}, lo};
  assign lo_x100     = (lo_ext <<< 6) + (lo_ext <<< 5) + (lo_ext <<< 2);
  assign interp_next = lo_x100 + {{(INTERP_W-16){slope[15]}}, slope};

  assign interp_abs = interp_b[INTERP_W-1] ? -interp_b : interp_b;

  assign q_prod = mag_c * DIV25_MUL;
  assign q      = q_prod[DIV25_SHIFT +: TEMP_W];
  assign temp_d = neg_c ? -q : q;

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      vc <= 1'b0;
      vd <= 1'b0;
    end else begin
      if (en_a) va <= in_valid;
      if (en_b) vb <= va;
      if (en_c) vc <= vb;
      if (en_d) vd <= vc;
    end
  end

  always_ff @(posedge clk) begin
    if (en_a) begin
      fresh_a <= in_item.fresh;
      idx_a   <= idx_in;
      frac_a  <= frac_full[FRAC_W-1:0];
    end
    if (en_b) begin
      fresh_b  <= fresh_a;
      interp_b <= interp_next;
    end
    if (en_c) begin
      fresh_c <= fresh_b;
      neg_c   <= interp_b[INTERP_W-1];
      mag_c   <= interp_abs[INTERP_MAG_W-1:0];
    end
    if (en_d) begin
      out_item.fresh <= fresh_c;
      out_item.temp  <= $signed(temp_d);
    end
  end

  assign out_valid = vd;

`ifndef SYNTHESIS
  // upper neighbor of the interpolation pair must stay inside the ROM
  a_idx_in_rom: assert property (@(posedge clk) disable iff (rst)
    va |-> (idx_a < 9'(ROM_DEPTH - 1)))
    else $error("interpolation index past end of ROM");
`endif

endmodule

### rtl/core/rtdca_avg.sv
// Moving average over a shift line of samples with a running sum, followed by
// the rounding division and the held-result output register.
// Depends on rtdca_pkg.
module rtdca_avg
  import rtdca_pkg::*;
#(
  parameter int AVG_WINDOW = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  sample_t                  in_item,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [TEMP_W-1:0] temperature
);

  localparam logic [SUM_W:0] HALF = (SUM_W+1)'(AVG_WINDOW / 2);
  localparam logic [AVG_RECIP_W-1:0] RECIP = AVG_RECIP_W'(
    ((64'd1 << AVG_RECIP_SHIFT) + 64'(AVG_WINDOW) - 64'd1) / 64'(AVG_WINDOW));

  logic en_s, en_m, en_o;
  logic vs, vm, vo;
  logic take;

  logic signed [TEMP_W-1:0] ring [AVG_WINDOW];
  logic signed [SUM_W-1:0]  sum, sum_next;
  logic signed [TEMP_W-1:0] oldest;

  logic                    fresh_s;
  logic signed [SUM_W-1:0] sum_s;

  logic [SUM_W:0]   rounded, rounded_abs;
  logic             fresh_m;
  logic             neg_m;
  logic [MAG_W-1:0] mag_m;

  logic [MAG_W+AVG_RECIP_W-1:0] avg_prod;
  logic [MAG_W-1:0]             q, avg;

  assign en_o     = !vo || out_ready;
  assign en_m     = !vm || en_o;
  assign en_s     = !vs || en_m;
  assign in_ready = en_s;
  assign take     = en_s && in_valid && in_item.fresh;

  // oldest sample leaves the far end of the line
  assign oldest   = ring[AVG_WINDOW-1];
  assign sum_next = sum - {{(SUM_W-TEMP_W){oldest[TEMP_W-1]}}, oldest}
                  + {{(SUM_W-TEMP_W){in_item.temp[TEMP_W-1]}}, in_item.temp};

  always_ff @(posedge clk) begin
    if (rst) begin
      sum <= '0;
      for (int i = 0; i < AVG_WINDOW; i++) ring[i] <= '0;
    end else if (take) begin
      sum     <= sum_next;
      ring[0] <= in_item.temp;
      for (int i = 1; i < AVG_WINDOW; i++) ring[i] <= ring[i-1];
    end
  end

  // C-style division: round by adding half, then truncate the magnitude
  assign rounded     = {sum_s[SUM_W-1], sum_s} + HALF;
  assign rounded_abs = rounded[SUM_W] ? -rounded : rounded;

  assign avg_prod = mag_m * RECIP;
  assign q        = avg_prod[AVG_RECIP_SHIFT +: MAG_W];
  assign avg      = neg_m ? -q : q;

  always_ff @(posedge clk) begin
    if (rst) begin
      vs          <= 1'b0;
      vm          <= 1'b0;
      vo          <= 1'b0;
      temperature <= '0;
    end else begin
      if (en_s) vs <= in_valid;
      if (en_m) vm <= vs;
      if (en_o) begin
        vo <= vm;
        // a stale reading repeats the held result
        if (vm && fresh_m) temperature <= $signed(avg[TEMP_W-1:0]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en_s) begin
      fresh_s <= in_item.fresh;
      sum_s   <= sum_next;
    end
    if (en_m) begin
      fresh_m <= fresh_s;
      neg_m   <= rounded[SUM_W];
      mag_m   <= rounded_abs[MAG_W-1:0];
    end
  end

  assign out_valid = vo;

`ifndef SYNTHESIS
  a_sum_only_on_fresh: assert property (@(posedge clk) disable iff (rst)
    !take |=> $stable(sum))
    else $error("running sum changed without a fresh sample");

  a_stale_holds: assert property (@(posedge clk) disable iff (rst)
    (en_o && vm && !fresh_m) |=> $stable(temperature))
    else $error("stale reading changed the held temperature");

  a_sign_kept: assert property (@(posedge clk) disable iff (rst)
    (en_o && vm && fresh_m && !neg_m) |=> !temperature[TEMP_W-1])
    else $error("non-negative average came out negative");
`endif

endmodule

### rtl/core/rtd_code_to_temperature_avg.sv
// Throughput: one item per cycle unless out_ready stalls the pipeline;
// the fully pipelined datapath and the running-sum update carry one item
// per clock.
// Reset clears all valid flags, the held temperature, the running sum and
// the sample history to zero; the first results ramp up from zero.
// Top level: input register, interpolation pipeline, averaging stage.
// Depends on rtdca_pkg, rtdca_interp, rtdca_avg.
module rtd_code_to_temperature_avg
  import rtdca_pkg::*;
#(
  parameter int AVG_WINDOW = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     fresh,
  input  logic [CODE_W-1:0]        resistance_code,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [TEMP_W-1:0] temperature
);

  logic     v0;
  logic     en0;
  reading_t item0;

  logic     interp_ready;
  logic     smp_valid;
  logic     smp_ready;
  sample_t  smp_item;

  assign en0      = !v0 || interp_ready;
  assign in_ready = en0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (en0) begin
      v0 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en0) begin
      item0.fresh <= fresh;
      item0.code  <= resistance_code;
    end
  end

  rtdca_interp u_interp (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v0),
    .in_ready  (interp_ready),
    .in_item   (item0),
    .out_valid (smp_valid),
    .out_ready (smp_ready),
    .out_item  (smp_item)
  );

  rtdca_avg #(
    .AVG_WINDOW (AVG_WINDOW)
  ) u_avg (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (smp_valid),
    .in_ready    (smp_ready),
    .in_item     (smp_item),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .temperature (temperature)
  );

endmodule
